/* rtl/cagb_pkg.sv */
// Shared types and constants for the clipped alpha glyph blend block.
`timescale 1ns / 1ps

package cagb_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_TOP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_BOTTOM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLOR  = 3'd4;

   // Input word kinds
   localparam logic KIND_BEGIN  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Coverage codes and blend scale
   localparam logic [7:0] COV_NONE   = 8'd0;
   localparam logic [7:0] COV_OPAQUE = 8'd255;
   localparam logic [8:0] BLEND_ONE  = 9'd256;

   // Port widths
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_DATA_W = 32;

   // Clip window and text color as seen by the back end
   typedef struct packed {
      logic signed [15:0] clip_left;
      logic signed [15:0] clip_top;
      logic signed [15:0] clip_right;
      logic signed [15:0] clip_bottom;
      logic [31:0]        text_color;
   } cagb_cfg_type;

   // One classified word between front and back
   typedef struct packed {
      logic               sample;   // active sample, position valid
      logic               done;     // last word of the glyph
      logic signed [16:0] pos_x;    // exact column
      logic signed [16:0] pos_y;    // exact row
      logic [7:0]         coverage;
      logic [31:0]        dest_color;
   } cagb_entry_type;

endpackage

/* rtl/cagb_front.sv */
// Front end: glyph state, raster counters and sample classification.
`timescale 1ns / 1ps

module cagb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     kind,
   input  logic signed [15:0]       glyph_x,
   input  logic signed [15:0]       glyph_y,
   input  logic [7:0]               glyph_width,
   input  logic [7:0]               glyph_height,
   input  logic [7:0]               coverage,
   input  logic [31:0]              dest_color,
   output cagb_pkg::cagb_entry_type entry
);

   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   logic [7:0]         col_ff, col_in;
   logic [7:0]         row_ff, row_in;
   logic               active_ff, active_in;
   logic [8:0]         col_next;
   logic [8:0]         row_next;
   logic               row_end;
   logic               glyph_end;

   assign col_next  = {1'b0, col_ff} + 9'd1;
   assign row_next  = {1'b0, row_ff} + 9'd1;
   assign row_end   = col_next >= {1'b0, width_ff};
   assign glyph_end = row_end && (row_next >= {1'b0, height_ff});

   // Classify the word and form its position
   always_comb begin
      entry            = '0;
      entry.coverage   = coverage;
      entry.dest_color = dest_color;
      if (kind == cagb_pkg::KIND_BEGIN) begin
         entry.done = (glyph_width == 8'd0) || (glyph_height == 8'd0);
      end else if (active_ff) begin
         entry.sample = 1'b1;
         entry.done   = glyph_end;
         entry.pos_x  = $signed({origin_x_ff[15], origin_x_ff} + {9'd0, col_ff});
         entry.pos_y  = $signed({origin_y_ff[15], origin_y_ff} + {9'd0, row_ff});
      end
   end

   // Advance glyph state on each accepted word
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      active_in   = active_ff;
      if (push) begin
         if (kind == cagb_pkg::KIND_BEGIN) begin
            origin_x_in = glyph_x;
            origin_y_in = glyph_y;
            width_in    = glyph_width;
            height_in   = glyph_height;
            col_in      = 8'd0;
            row_in      = 8'd0;
            active_in   = (glyph_width != 8'd0) && (glyph_height != 8'd0);
         end else if (active_ff) begin
            if (glyph_end) begin
               col_in    = 8'd0;
               row_in    = 8'd0;
               active_in = 1'b0;
            end else if (row_end) begin
               col_in = 8'd0;
               row_in = row_next[7:0];
            end else begin
               col_in = col_next[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         active_ff   <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         active_ff   <= active_in;
      end
   end

   // Counters rest at zero whenever no glyph is in progress
   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (col_ff == 8'd0) && (row_ff == 8'd0))
      else $error("counters not cleared while idle");

   // An empty begin leaves no glyph active
   a_empty_begin: assert property (@(posedge clock) disable iff (reset)
      push && (kind == cagb_pkg::KIND_BEGIN) && (glyph_width == 8'd0) |=> !active_ff)
      else $error("empty glyph became active");

endmodule

/* rtl/cagb_queue.sv */
// Short word queue between the front and back ends.
`timescale 1ns / 1ps

module cagb_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cagb_pkg::cagb_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output cagb_pkg::cagb_entry_type head
);

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   cagb_pkg::cagb_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == COUNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue overfilled");

endmodule

/* rtl/cagb_back.sv */
// Back end: clip test, coverage blend and output register.
`timescale 1ns / 1ps

module cagb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cagb_pkg::cagb_cfg_type   cfg,
   input  logic                     empty,
   input  cagb_pkg::cagb_entry_type head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     write_pixel,
   output logic [15:0]              pixel_x,
   output logic [15:0]              pixel_y,
   output logic [31:0]              pixel_color,
   output logic                     glyph_done
);

   logic        valid_ff, valid_in;
   logic        write_ff, write_in;
   logic [15:0] x_ff, y_ff;
   logic [31:0] color_ff, color_in;
   logic        done_ff;
   logic        in_clip;
   logic [8:0]  inv_a;

   // Blend one channel: (dst*(256-a) + col*a) >> 8
   function automatic logic [7:0] blend(input logic [7:0] dst, input logic [7:0] col,
                                        input logic [7:0] a, input logic [8:0] inv);
      logic [16:0] dst_part;
      logic [16:0] col_part;
      logic [16:0] sum;
      dst_part = {9'd0, dst} * {8'd0, inv};
      col_part = {9'd0, col} * {9'd0, a};
      sum      = dst_part + col_part;
      return sum[15:8];
   endfunction

   assign inv_a = cagb_pkg::BLEND_ONE - {1'b0, head.coverage};

   assign in_clip = (head.pos_x >= $signed({cfg.clip_left[15], cfg.clip_left}))
                 && (head.pos_x <  $signed({cfg.clip_right[15], cfg.clip_right}))
                 && (head.pos_y >= $signed({cfg.clip_top[15], cfg.clip_top}))
                 && (head.pos_y <  $signed({cfg.clip_bottom[15], cfg.clip_bottom}));

   // Take the head word whenever the output register frees up
   assign pop = !empty && (!valid_ff || rsp_tready);

   // Pick the pixel color
   always_comb begin
      write_in = head.sample && in_clip && (head.coverage != cagb_pkg::COV_NONE);
      color_in = '0;
      if (write_in) begin
         if (head.coverage == cagb_pkg::COV_OPAQUE) begin
            color_in = cfg.text_color;
         end else begin
            color_in = {cfg.text_color[31:24],
                        blend(head.dest_color[23:16], cfg.text_color[23:16],
                              head.coverage, inv_a),
                        blend(head.dest_color[15:8], cfg.text_color[15:8],
                              head.coverage, inv_a),
                        blend(head.dest_color[7:0], cfg.text_color[7:0],
                              head.coverage, inv_a)};
         end
      end
   end

   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the output word
   always_ff @(posedge clock) begin
      if (pop) begin
         write_ff <= write_in;
         x_ff     <= head.pos_x[15:0];
         y_ff     <= head.pos_y[15:0];
         color_ff <= color_in;
         done_ff  <= head.done;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign write_pixel = write_ff;
   assign pixel_x     = x_ff;
   assign pixel_y     = y_ff;
   assign pixel_color = color_ff;
   assign glyph_done  = done_ff;

   // A skipped pixel carries no color
   a_skip_color: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !write_ff |-> color_ff == 32'd0)
      else $error("color on a skipped pixel");

   // A word leaves the queue only into a free output register
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      pop && valid_ff |-> rsp_tready)
      else $error("output word overwritten");

endmodule

/* rtl/clipped_alpha_glyph_blend.sv */
// Top level: csr registers, front end, word queue and back end.
// A result word is registered in a queue slot and then in the output register.
// Throughput: one word per cycle sustained; the front end stalls only when the
// queue of QUEUE_DEPTH words is full because the result side is held off.
// Reset (synchronous, active high) clears the clip window, text color, glyph
// state, queue and output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module clipped_alpha_glyph_blend #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [15:0] glyph_x, [31:16] glyph_y, [39:32] glyph_width, [47:40] glyph_height,
   // [55:48] coverage, [87:56] dest_color
   input  logic [cagb_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [0] kind
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] pixel_x, [31:16] pixel_y, [63:32] pixel_color
   output logic [cagb_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] write_pixel
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [cagb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cagb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   cagb_pkg::cagb_cfg_type   cfg_ff, cfg_in;
   cagb_pkg::cagb_entry_type front_entry;
   cagb_pkg::cagb_entry_type head;
   logic                     push;
   logic                     full;
   logic                     empty;
   logic                     pop;
   logic [15:0]              pixel_x;
   logic [15:0]              pixel_y;
   logic [31:0]              pixel_color;

   // Decode csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cagb_pkg::CSR_CLIP_LEFT:   cfg_in.clip_left   = csr_wdata[15:0];
            cagb_pkg::CSR_CLIP_TOP:    cfg_in.clip_top    = csr_wdata[15:0];
            cagb_pkg::CSR_CLIP_RIGHT:  cfg_in.clip_right  = csr_wdata[15:0];
            cagb_pkg::CSR_CLIP_BOTTOM: cfg_in.clip_bottom = csr_wdata[15:0];
            cagb_pkg::CSR_TEXT_COLOR:  cfg_in.text_color  = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   cagb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .kind         (req_tuser),
      .glyph_x      (req_tdata[15:0]),
      .glyph_y      (req_tdata[31:16]),
      .glyph_width  (req_tdata[39:32]),
      .glyph_height (req_tdata[47:40]),
      .coverage     (req_tdata[55:48]),
      .dest_color   (req_tdata[87:56]),
      .entry        (front_entry)
   );

   cagb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   cagb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .empty       (empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .write_pixel (rsp_tuser),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .glyph_done  (rsp_tlast)
   );

   assign rsp_tdata = {pixel_color, pixel_y, pixel_x};

endmodule
